@@ hdl/hvd_pkg.sv @@
package hvd_pkg;

  // CORDIC datapath width, signed
  localparam int CW = 34;
  typedef logic signed [CW-1:0] cw_t;

  // Square root datapath
  localparam int SQW      = 62;
  localparam int SQ_STEPS = 31;

  localparam cw_t          CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0]  PI_Q29      = 31'd1686629713;

  // Reciprocals for the degree-to-binary-angle conversion (2^38 / divisor, floored)
  localparam logic [29:0]  RECIP_360 = 30'd763549741;
  localparam logic [31:0]  RECIP_90  = 32'd3054198966;
  localparam int           DEG_TURN  = 360;
  localparam int           DIV_FINE  = 90;
  localparam int           RND_FINE  = 45;

  // atan(2^-i) as a binary angle, 2^30 = 90 degrees
  localparam logic [31:0] ATAN_BAM [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

endpackage

@@ hdl/hvd_rot.sv @@
module hvd_rot #(
  parameter int STEPS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [31:0]   ang_i,
  output logic          valid_o,
  output hvd_pkg::cw_t  cos_o,
  output hvd_pkg::cw_t  sin_o
);

  hvd_pkg::cw_t x_q [STEPS+1];
  hvd_pkg::cw_t y_q [STEPS+1];
  hvd_pkg::cw_t z_q [STEPS+1];
  logic         v_q [STEPS+1];
  logic         flip_q [STEPS+1];

  logic        flip_d;
  logic [31:0] ang_d;

  // fold the second and third quadrants onto the right half plane
  assign flip_d = ang_i[31] ^ ang_i[30];
  assign ang_d  = {ang_i[31] ^ flip_d, ang_i[30:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= hvd_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= {{(hvd_pkg::CW-32){ang_d[31]}}, ang_d};
      flip_q[0] <= flip_d;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    localparam hvd_pkg::cw_t AT = {{(hvd_pkg::CW-32){1'b0}}, hvd_pkg::ATAN_BAM[k]};
    hvd_pkg::cw_t xs, ys;
    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[k+1] <= flip_q[k];
        if (!z_q[k][hvd_pkg::CW-1]) begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          z_q[k+1] <= z_q[k] - AT;
        end else begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          z_q[k+1] <= z_q[k] + AT;
        end
      end
    end
  end

  assign valid_o = v_q[STEPS];
  assign cos_o   = flip_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
  assign sin_o   = flip_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];

endmodule

@@ hdl/hvd_vec.sv @@
module hvd_vec #(
  parameter int STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [30:0] ys_i,
  input  logic [30:0] xs_i,
  output logic        valid_o,
  output logic [30:0] z_o
);

  hvd_pkg::cw_t x_q [STEPS+1];
  hvd_pkg::cw_t y_q [STEPS+1];
  hvd_pkg::cw_t z_q [STEPS+1];
  logic         v_q [STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= {{(hvd_pkg::CW-31){1'b0}}, xs_i};
      y_q[0] <= {{(hvd_pkg::CW-31){1'b0}}, ys_i};
      z_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    localparam hvd_pkg::cw_t AT = {{(hvd_pkg::CW-32){1'b0}}, hvd_pkg::ATAN_BAM[k]};
    hvd_pkg::cw_t xs, ys;
    logic         y_pos;
    assign xs    = x_q[k] >>> k;
    assign ys    = y_q[k] >>> k;
    assign y_pos = !y_q[k][hvd_pkg::CW-1] && (y_q[k] != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_pos) begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          z_q[k+1] <= z_q[k] + AT;
        end else begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          z_q[k+1] <= z_q[k] - AT;
        end
      end
    end
  end

  // clamp a negative residue at zero
  assign valid_o = v_q[STEPS];
  assign z_o     = z_q[STEPS][hvd_pkg::CW-1] ? '0 : z_q[STEPS][30:0];

endmodule

@@ hdl/haversine_distance.sv @@
// Great circle distance between two points, one result per point pair.
//
// Input stream: one transfer carries lat_a, lon_a, lat_b, lon_b in signed
// degrees scaled by 2^ANGLE_FRAC_BITS. Output stream: one transfer carries the
// distance in km scaled by 2^DIST_FRAC_BITS, saturating at all ones.
// The sphere radius in whole km is written through cfg_we_i / cfg_wdata_i
// only while no pair is in flight (user's duty, unenforced); reset loads 6371.
//
// The pipeline holds 4 stages of degree to binary angle conversion, a
// rotation CORDIC of CORDIC_STEPS+1 stages, 3 multiply stages, a 31 stage
// square root that retires one root bit per stage, a vectoring CORDIC of
// CORDIC_STEPS+1 stages, 4 scaling stages and the output register. Every
// stage holds one pair, so while the skid register is empty a new pair is
// taken each cycle and the sustained rate is one pair per cycle.
//
// Reset empties the pipeline. When the receiver stalls, a skid register
// catches the pair leaving the pipeline and s_axis_tready drops; nothing is
// dropped or repeated, and the pipeline resumes once the skid register drains.
module haversine_distance #(
  parameter int ANGLE_FRAC_BITS = 20,
  parameter int DIST_FRAC_BITS  = 10,
  parameter int CORDIC_STEPS    = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85], zero pad [119:114]
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance[31:0]
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int BSH = 32 - ANGLE_FRAC_BITS;   // whole degree turns into binary angle
  localparam int RSH = 30 - ANGLE_FRAC_BITS;   // remainder scaling before the fine divide
  localparam int DSH = 30 - DIST_FRAC_BITS;
  localparam logic [49:0] DRND = 50'(1) << (DSH - 1);

  logic en;
  logic out_valid_q, skid_valid_q;
  logic [31:0] out_q, skid_q;

  // the whole pipeline advances unless the skid register is holding a result
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  // ---------------- radius register ----------------
  logic [15:0] radius_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd6371;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // ---------------- degrees to binary angle ----------------
  // q = floor((|v| * 2^(32-AFB) + 180) / 360), done as a coarse divide of |v|
  // by 360 followed by a fine divide of the scaled remainder.
  logic [28:0] fld [4];
  logic [31:0] bam_q [4];
  logic        vb_q [4];

  assign fld[0] = {s_axis_tdata[27], s_axis_tdata[27:0]};
  assign fld[1] = s_axis_tdata[56:28];
  assign fld[2] = {s_axis_tdata[84], s_axis_tdata[84:57]};
  assign fld[3] = s_axis_tdata[113:85];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q[0] <= 1'b0;
      vb_q[1] <= 1'b0;
      vb_q[2] <= 1'b0;
      vb_q[3] <= 1'b0;
    end else if (en) begin
      vb_q[0] <= s_axis_tvalid;
      vb_q[1] <= vb_q[0];
      vb_q[2] <= vb_q[1];
      vb_q[3] <= vb_q[2];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_bam
    logic        neg_d;
    logic [28:0] mag_d;
    logic [28:0] m1_q;
    logic        n1_q, n2_q, n3_q;
    logic [58:0] p1_q;
    logic [20:0] h_est, h2_d, h2_q, h3_q;
    logic [29:0] r_est, r_fix;
    logic [8:0]  r2_d, r2_q;
    logic [31:0] w_d, w3_q;
    logic [63:0] p3_q;
    logic [25:0] q_est;
    logic [31:0] q_rem, q_d, whole_d, bam_u, bam_d;

    assign neg_d = fld[l][28];
    assign mag_d = neg_d ? 29'(-fld[l]) : fld[l];

    always_ff @(posedge clk_i) begin
      if (en) begin
        m1_q <= mag_d;
        n1_q <= neg_d;
        p1_q <= 59'(mag_d) * 59'(hvd_pkg::RECIP_360);
      end
    end

    // estimate is exact or one low; correct with one compare
    assign h_est = p1_q[58:38];
    assign r_est = 30'(m1_q) - 30'(h_est) * 30'(hvd_pkg::DEG_TURN);
    assign r_fix = r_est - 30'(hvd_pkg::DEG_TURN);
    assign h2_d  = (r_est >= 30'(hvd_pkg::DEG_TURN)) ? h_est + 21'd1 : h_est;
    assign r2_d  = (r_est >= 30'(hvd_pkg::DEG_TURN)) ? r_fix[8:0] : r_est[8:0];

    always_ff @(posedge clk_i) begin
      if (en) begin
        h2_q <= h2_d;
        r2_q <= r2_d;
        n2_q <= n1_q;
      end
    end

    assign w_d = (32'(r2_q) << RSH) + 32'(hvd_pkg::RND_FINE);

    always_ff @(posedge clk_i) begin
      if (en) begin
        w3_q <= w_d;
        p3_q <= 64'(w_d) * 64'(hvd_pkg::RECIP_90);
        h3_q <= h2_q;
        n3_q <= n2_q;
      end
    end

    assign q_est   = p3_q[63:38];
    assign q_rem   = w3_q - 32'(q_est) * 32'(hvd_pkg::DIV_FINE);
    assign q_d     = (q_rem >= 32'(hvd_pkg::DIV_FINE)) ? 32'(q_est) + 32'd1 : 32'(q_est);
    assign whole_d = 32'(64'(h3_q) << BSH);
    assign bam_u   = whole_d + q_d;
    assign bam_d   = n3_q ? 32'd0 - bam_u : bam_u;

    always_ff @(posedge clk_i) begin
      if (en) begin
        bam_q[l] <= bam_d;
      end
    end
  end

  // ---------------- sine / cosine ----------------
  logic [31:0]  rot_ang [4];
  logic [31:0]  dlat, dlon;
  logic [3:0]   rot_valid;
  hvd_pkg::cw_t rot_cos [4];
  hvd_pkg::cw_t rot_sin [4];

  assign dlat       = bam_q[2] - bam_q[0];
  assign dlon       = bam_q[3] - bam_q[1];
  assign rot_ang[0] = bam_q[0];
  assign rot_ang[1] = bam_q[2];
  assign rot_ang[2] = dlat >> 1;
  assign rot_ang[3] = dlon >> 1;

  for (genvar i = 0; i < 4; i++) begin : g_rot
    hvd_rot #(
      .STEPS(CORDIC_STEPS)
    ) u_rot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(vb_q[3]),
      .ang_i  (rot_ang[i]),
      .valid_o(rot_valid[i]),
      .cos_o  (rot_cos[i]),
      .sin_o  (rot_sin[i])
    );
  end

  // ---------------- haversine term ----------------
  logic [31:0]        abs1, abs2;
  logic signed [31:0] ca32, cb32, ccs32;
  logic [63:0]        sq1_q, sq2_q;
  logic signed [63:0] cc_q;
  logic [33:0]        ss1_q;
  logic [32:0]        ss2;
  logic signed [64:0] t_q;
  logic signed [35:0] asum;
  logic [30:0]        a_d, a_q;
  logic               pv_q [3];

  assign abs1 = rot_sin[2][hvd_pkg::CW-1] ? 32'(-rot_sin[2]) : 32'(rot_sin[2]);
  assign abs2 = rot_sin[3][hvd_pkg::CW-1] ? 32'(-rot_sin[3]) : 32'(rot_sin[3]);
  assign ca32 = $signed(rot_cos[0][31:0]);
  assign cb32 = $signed(rot_cos[1][31:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq1_q <= 64'(abs1) * 64'(abs1);
      sq2_q <= 64'(abs2) * 64'(abs2);
      cc_q  <= ca32 * cb32;
    end
  end

  assign ss2   = sq2_q[62:30];
  assign ccs32 = $signed(cc_q[61:30]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ss1_q <= sq1_q[63:30];
      t_q   <= ccs32 * $signed(ss2);
    end
  end

  assign asum = $signed({2'b00, ss1_q}) + $signed({t_q[64], t_q[64:30]});

  // clamp a to [0, 1.0] so that 1-a never goes negative
  always_comb begin
    if (asum[35]) begin
      a_d = '0;
    end else if (asum > 36'sd1073741824) begin
      a_d = 31'h4000_0000;
    end else begin
      a_d = asum[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
      pv_q[1] <= 1'b0;
      pv_q[2] <= 1'b0;
    end else if (en) begin
      pv_q[0] <= &rot_valid;
      pv_q[1] <= pv_q[0];
      pv_q[2] <= pv_q[1];
    end
  end

  // ---------------- square roots, one bit per stage ----------------
  logic [hvd_pkg::SQW-1:0] sq_v0 [2];
  logic [hvd_pkg::SQW-1:0] sv_q [2][hvd_pkg::SQ_STEPS];
  logic [hvd_pkg::SQW-1:0] sr_q [2][hvd_pkg::SQ_STEPS];
  logic                    sqv_q [hvd_pkg::SQ_STEPS];
  logic [30:0]             one_minus_a;

  assign one_minus_a = 31'h4000_0000 - a_q;
  assign sq_v0[0]    = hvd_pkg::SQW'({a_q, 30'd0});
  assign sq_v0[1]    = hvd_pkg::SQW'({one_minus_a, 30'd0});

  for (genvar j = 0; j < hvd_pkg::SQ_STEPS; j++) begin : g_sqrt
    localparam logic [hvd_pkg::SQW-1:0] SBIT = hvd_pkg::SQW'(1) << (60 - 2 * j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[j] <= 1'b0;
      end else if (en) begin
        if (j == 0) begin
          sqv_q[j] <= pv_q[2];
        end else begin
          sqv_q[j] <= sqv_q[(j == 0) ? 0 : j-1];
        end
      end
    end

    for (genvar n = 0; n < 2; n++) begin : g_lane
      logic [hvd_pkg::SQW-1:0] sq_pv, sq_pr, sq_tr;
      if (j == 0) begin : g_first
        assign sq_pv = sq_v0[n];
        assign sq_pr = '0;
      end else begin : g_next
        assign sq_pv = sv_q[n][j-1];
        assign sq_pr = sr_q[n][j-1];
      end
      assign sq_tr = sq_pr + SBIT;

      always_ff @(posedge clk_i) begin
        if (en) begin
          if (sq_pv >= sq_tr) begin
            sv_q[n][j] <= sq_pv - sq_tr;
            sr_q[n][j] <= (sq_pr >> 1) + SBIT;
          end else begin
            sv_q[n][j] <= sq_pv;
            sr_q[n][j] <= sq_pr >> 1;
          end
        end
      end
    end
  end

  // ---------------- central angle ----------------
  logic        vec_valid;
  logic [30:0] vec_z;

  hvd_vec #(
    .STEPS(CORDIC_STEPS)
  ) u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(sqv_q[hvd_pkg::SQ_STEPS-1]),
    .ys_i   (sr_q[0][hvd_pkg::SQ_STEPS-1][30:0]),
    .xs_i   (sr_q[1][hvd_pkg::SQ_STEPS-1][30:0]),
    .valid_o(vec_valid),
    .z_o    (vec_z)
  );

  // ---------------- radians, radius, saturation ----------------
  logic [61:0] fp_q;
  logic [32:0] frad_q;
  logic [48:0] fd_q;
  logic [49:0] dsum, dsh;
  logic [31:0] fin_d, fin_q;
  logic        fv_q [3];
  logic        fin_valid_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fp_q   <= 62'(vec_z) * 62'(hvd_pkg::PI_Q29);
      frad_q <= 33'((fp_q + (62'(1) << 28)) >> 29);
      fd_q   <= 49'(radius_q) * 49'(frad_q);
      fin_q  <= fin_d;
    end
  end

  assign dsum  = 50'(fd_q) + DRND;
  assign dsh   = dsum >> DSH;
  assign fin_d = (|dsh[49:32]) ? 32'hFFFF_FFFF : dsh[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q[0]     <= 1'b0;
      fv_q[1]     <= 1'b0;
      fv_q[2]     <= 1'b0;
      fin_valid_q <= 1'b0;
    end else if (en) begin
      fv_q[0]     <= vec_valid;
      fv_q[1]     <= fv_q[0];
      fv_q[2]     <= fv_q[1];
      fin_valid_q <= fv_q[2];
    end
  end

  // ---------------- output register and skid ----------------
  logic take, pipe_fire;

  assign take      = !out_valid_q || m_axis_tready;
  assign pipe_fire = en && fin_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= pipe_fire;
      end
    end else if (pipe_fire) begin
      // hold the leaving result until the output frees up
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_valid_q ? skid_q : fin_q;
    end
    if (!take && pipe_fire) begin
      skid_q <= fin_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // ---------------- checks ----------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_valid_q && en && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("result left the pipeline during a stall without being caught");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && m_axis_tready) |=> (!skid_valid_q && out_valid_q))
    else $error("skid register did not drain into the output register");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready) |=> $stable(skid_q))
    else $error("held result changed during a stall");

endmodule

@@ tb/haversine_distance_tb.sv @@
`timescale 1ns / 100ps

module haversine_distance_tb;

  localparam int  TRIG_STEPS  = 24;
  localparam int  PIPE_CYCLES = 2 * TRIG_STEPS + 45;
  localparam int  STALL_LIMIT = 4000;
  localparam longint LAT_MAX  = 94371840;
  localparam longint LON_MAX  = 188743680;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85], zero pad [119:114]
  logic [119:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // distance[31:0]
  logic [31:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic [15:0]  cfg_wdata = '0;

  // Radius as the block should hold it, and the distances still in flight.
  logic [15:0]  radius_km = 16'd6371;
  logic [31:0]  pending_dist[$];
  int           err_cnt = 0;
  int           pairs_sent = 0;
  int           dists_seen = 0;
  bit           tx_gaps = 1'b1;
  bit           rx_gaps = 1'b1;
  int           quiet_cycles = 0;

  haversine_distance dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Distance predictor, fixed point throughout
  // ---------------------------------------------------------------------------

  // Degrees * 2^20 to a 32-bit binary angle, rounding half away from zero.
  function automatic logic [31:0] bin_angle(longint deg);
    longint unsigned den, mag, q;
    logic [31:0]     r;
    den = 64'd360 << 20;
    mag = (deg < 0) ? -deg : deg;
    q   = ((mag << 32) + den / 2) / den;
    r   = q[31:0];
    return (deg < 0) ? -r : r;
  endfunction

  // Rotation CORDIC; fold quadrants 1 and 2 over by half a turn.
  function automatic void rotate_sincos(logic [31:0] ang, output longint c,
                                        output longint s);
    bit     flip;
    longint x, y, z, nx;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'($signed(ang));
    x = longint'(hvd_pkg::CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < TRIG_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(hvd_pkg::ATAN_BAM[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(hvd_pkg::ATAN_BAM[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint half_sin_sq(logic [31:0] diff);
    longint c, s;
    rotate_sincos({1'b0, diff[31:1]}, c, s);
    return (s * s) >>> 30;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC, angle of (x, y) as a binary angle; a negative residue
  // is clamped at zero.
  function automatic longint vector_angle(longint y, longint x);
    longint z, nx;
    z = 0;
    for (int i = 0; i < TRIG_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(hvd_pkg::ATAN_BAM[i]);
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(hvd_pkg::ATAN_BAM[i]);
      end
      x = nx;
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic logic [31:0] great_circle_km(longint lat_a, longint lon_a,
                                                  longint lat_b, longint lon_b,
                                                  logic [15:0] radius);
    logic [31:0]     la, oa, lb, ob;
    longint          ca, sa, cb, sb, hav, ys, xs, z;
    longint unsigned rad, dist_km;
    la = bin_angle(lat_a);
    oa = bin_angle(lon_a);
    lb = bin_angle(lat_b);
    ob = bin_angle(lon_b);
    rotate_sincos(la, ca, sa);
    rotate_sincos(lb, cb, sb);
    hav = half_sin_sq(lb - la) +
          ((((ca * cb) >>> 30) * half_sin_sq(ob - oa)) >>> 30);
    // Rounding can push the haversine outside [0, 1]; clamp it.
    if (hav < 0) hav = 0;
    if (hav > (64'sd1 << 30)) hav = 64'sd1 << 30;
    ys      = longint'(floor_sqrt(longint'(hav) << 30));
    xs      = longint'(floor_sqrt(((64'sd1 << 30) - hav) << 30));
    z       = vector_angle(ys, xs);
    rad     = (longint'(z) * longint'(hvd_pkg::PI_Q29) + (64'd1 << 28)) >> 29;
    dist_km = (longint'(radius) * rad + (64'd1 << 19)) >> 20;
    return (dist_km > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dist_km[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Transfers
  // ---------------------------------------------------------------------------

  // Offer one point pair; record its distance when the transfer happens.
  task automatic send_pair(longint lat_a, longint lon_a, longint lat_b, longint lon_b);
    logic [27:0] f_lat_a, f_lat_b;
    logic [28:0] f_lon_a, f_lon_b;
    f_lat_a = lat_a[27:0];
    f_lon_a = lon_a[28:0];
    f_lat_b = lat_b[27:0];
    f_lon_b = lon_b[28:0];
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, f_lon_b, f_lat_b, f_lon_a, f_lat_a};
    do @(posedge clk_i); while (!s_tready);
    pending_dist.push_back(great_circle_km($signed(f_lat_a), $signed(f_lon_a),
                                           $signed(f_lat_b), $signed(f_lon_b),
                                           radius_km));
    pairs_sent++;
  endtask

  // Drop valid and hold until every expected distance is back.
  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk_i);
  endtask

  // Radius is written only with the pipeline empty.
  task automatic set_radius(logic [15:0] r);
    drain_pipe();
    repeat (PIPE_CYCLES + 8) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    radius_km = r;
  endtask

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  // Any bit pattern of the field, including latitudes past the poles.
  function automatic longint rand_bits(int w);
    logic [31:0] v;
    v = $urandom();
    return (w == 28) ? longint'($signed(v[27:0])) : longint'($signed(v[28:0]));
  endfunction

  task automatic send_random_pair();
    longint la, oa, lb, ob;
    int     kind;
    kind = $urandom_range(0, 9);
    la = rand_span(LAT_MAX);
    oa = rand_span(LON_MAX);
    if (kind < 6) begin
      lb = rand_span(LAT_MAX);
      ob = rand_span(LON_MAX);
    end else if (kind < 8) begin
      // Nearby points: small-angle end of the atan2 and square roots
      lb = la + rand_span(longint'($urandom_range(1, 1 << 20)));
      ob = oa + rand_span(longint'($urandom_range(1, 1 << 20)));
      if (lb > LAT_MAX) lb = LAT_MAX;
      if (lb < -LAT_MAX) lb = -LAT_MAX;
    end else begin
      la = rand_bits(28);
      oa = rand_bits(29);
      lb = rand_bits(28);
      ob = rand_bits(29);
    end
    send_pair(la, oa, lb, ob);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // Stall the output in bursts of random length.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (m_tvalid && m_tready) begin
      dists_seen++;
      if (pending_dist.size() == 0) begin
        $error("distance %0d arrived with nothing outstanding", m_tdata);
        err_cnt++;
      end else begin
        want = pending_dist.pop_front();
        if (m_tdata !== want) begin
          $error("distance: expected %0d, got %0d", want, m_tdata);
          err_cnt++;
        end
      end
    end
  end

  // End the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ends with the last pair offered; the next test drains the pipe first.
  task automatic test_directed();
    send_pair(0, 0, 0, 0);                               // same point
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);                  // pole to pole
    send_pair(0, 0, 0, LON_MAX);                         // antipodes on equator
    send_pair(0, -LON_MAX, 0, LON_MAX);                  // wrap: same meridian
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    send_pair(0, 0, 0, 1);                               // smallest step
    send_pair(1, 0, 0, 0);
    send_pair(-1, -1, 0, 0);
    send_pair(45 << 20, 90 << 20, -45 << 20, -90 << 20); // antipodal, a clamps
    send_pair(30 << 20, 10 << 20, -30 << 20, -170 << 20);
    // Field extremes: latitudes past the poles, longitudes past a half turn
    send_pair(-(1 << 27), -(1 << 28), (1 << 27) - 1, (1 << 28) - 1);
    send_pair((1 << 27) - 1, (1 << 28) - 1, -(1 << 27), -(1 << 28));
    send_pair(100 << 20, 0, -100 << 20, 0);
    send_pair(0, 400 << 20, 0, 40 << 20);                // wraps in the field
    send_pair(51 << 20, 0, 40 << 20, -74 << 20);
    send_pair(-33 << 20, 151 << 20, 35 << 20, 139 << 20);
  endtask

  task automatic test_radius_sweep();
    logic [15:0] radii [5] = '{16'hFFFF, 16'd1, 16'd0, 16'd6371, 16'd12345};
    foreach (radii[k]) begin
      set_radius(radii[k]);
      send_pair(0, 0, 0, LON_MAX);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0);
      send_pair(10 << 20, 20 << 20, 11 << 20, 21 << 20);
      repeat (5) send_random_pair();
    end
    drain_pipe();
  endtask

  // Random pairs; at each phase boundary drain the pipe and load a new radius.
  task automatic test_random_stream();
    for (int n = 0; n < 1000; n++) begin
      if (n > 0 && n % 200 == 0) begin
        case ($urandom_range(0, 3))
          0: set_radius(16'hFFFF);
          1: set_radius(16'd1);
          default: set_radius(16'($urandom_range(1, 65535)));
        endcase
      end
      // Last stretch runs at full rate on both sides
      if (n == 850) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      send_random_pair();
    end
    drain_pipe();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_radius_sweep();
    test_random_stream();

    repeat (PIPE_CYCLES + 10) @(posedge clk_i);
    $display("Sent %0d point pairs, checked %0d distances across radii from 0 to 65535,",
             pairs_sent, dists_seen);
    $display("with random input and output stalls and a final full-rate stretch.");
    if (err_cnt == 0 && pending_dist.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ haversine_distance.f @@
hdl/hvd_pkg.sv
hdl/hvd_rot.sv
hdl/hvd_vec.sv
hdl/haversine_distance.sv
tb/haversine_distance_tb.sv
